/* sv/fsmff_pkg.sv */
`timescale 1ns / 1ps

package fsmff_pkg;

  localparam int CLASS_W   = 4;
  localparam int LANES     = 16;
  localparam int ROW_BITS  = CLASS_W * LANES;
  localparam int PAGE_W    = 10;
  localparam int BYTES_W   = 16;
  localparam int SHIFT_W   = 4;
  localparam int PADDR_W   = 2;
  localparam int PDATA_W   = 32;
  localparam int MAX_PAGES = 1 << PAGE_W;

  localparam logic [CLASS_W-1:0] MAX_CLASS   = 4'd15;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd8;

  localparam logic [PADDR_W-1:0] ADDR_BLOCK_SHIFT = 2'd0;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_FIND   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_FIND,
    ST_RESP
  } state_t;

endpackage

/* sv/free_space_map_first_fit.sv */
`timescale 1ns / 1ps

// Channel  Direction  Ports                                        Transfer
// in       input      in_command, in_page_index, in_free_bytes,    in_valid & in_ready
//                     in_required_bytes
// out      output     out_found, out_page_found                    out_valid & out_ready
// cfg      input      cfg_psel/penable/pwrite/paddr/pwdata/prdata  psel & penable & pwrite
//
// An update of a page in range reads the map row and then writes it back; any other update
// is dropped in its transfer cycle. A find compares the 16-class rows up to and including the
// first hit (at most ceil(min(PAGE_COUNT, 1024) / 16), 64 by default), read through the single
// map read port at one row a cycle; a find that needs more than fifteen classes skips the
// scan. Reset clears the per-row valid bits at once, with no clearing pass. A result waits
// in the output register; a find ending while it is still full waits before it.

module free_space_map_first_fit #(
  parameter int PAGE_COUNT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [fsmff_pkg::PAGE_W-1:0]        in_page_index,
  input  logic [fsmff_pkg::BYTES_W-1:0]       in_free_bytes,
  input  logic [fsmff_pkg::BYTES_W-1:0]       in_required_bytes,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [fsmff_pkg::PAGE_W-1:0]        out_page_found,

  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fsmff_pkg::PADDR_W-1:0]       cfg_paddr,
  input  logic [fsmff_pkg::PDATA_W-1:0]       cfg_pwdata,
  output logic [fsmff_pkg::PDATA_W-1:0]       cfg_prdata,
  output logic                                cfg_pready
);
  import fsmff_pkg::*;

  // Pages from 1024 up can never be written, so the map only covers the rest.
  localparam int SCAN_PAGES = (PAGE_COUNT < MAX_PAGES) ? PAGE_COUNT : MAX_PAGES;
  localparam int ROWS       = (SCAN_PAGES + LANES - 1) / LANES;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  state_t state_r, state_nxt;

  logic [SHIFT_W-1:0]  block_shift_r;
  logic [ROWS-1:0]     row_vld_r, row_vld_nxt;
  logic [ROW_W-1:0]    scan_row_r, scan_row_nxt;
  logic [ROW_W-1:0]    cmp_row_r, cmp_row_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [CLASS_W-1:0]  need_r, need_nxt;
  logic [CLASS_W-1:0]  cls_r, cls_nxt;
  logic [ROW_W-1:0]    upd_row_r, upd_row_nxt;
  logic [3:0]          upd_lane_r, upd_lane_nxt;
  logic                res_found_r, res_found_nxt;
  logic [PAGE_W-1:0]   res_page_r, res_page_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [PAGE_W-1:0]   out_page_r, out_page_nxt;

  logic [ROW_BITS-1:0] map_mem [ROWS];
  logic [ROW_BITS-1:0] rd_data_r;
  logic                rd_vld_r;
  logic                rd_en;
  logic [ROW_W-1:0]    rd_addr;
  logic                wr_en;
  logic [ROW_BITS-1:0] wr_data;

  logic [ROW_BITS-1:0] row_data;
  logic                hit_any;
  logic [3:0]          hit_lane;
  logic [BYTES_W-1:0]  req_m1, req_sh, free_sh;
  logic                need_big;
  logic                in_xfer, page_ok;
  logic                cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == ADDR_BLOCK_SHIFT) ?
                      PDATA_W'(block_shift_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_shift_r <= SHIFT_RESET;
    end else if (cfg_wr && cfg_paddr == ADDR_BLOCK_SHIFT) begin
      block_shift_r <= cfg_pwdata[SHIFT_W-1:0];
    end
  end

  // A request of zero bytes is rounded as if it were one byte.
  assign req_m1   = (in_required_bytes == '0) ? '0 : in_required_bytes - BYTES_W'(1);
  assign req_sh   = req_m1 >> block_shift_r;
  assign need_big = (|req_sh[BYTES_W-1:CLASS_W]) || (req_sh[CLASS_W-1:0] == MAX_CLASS);
  assign free_sh  = in_free_bytes >> block_shift_r;

  assign in_xfer  = in_valid & in_ready;
  assign page_ok  = 32'(in_page_index) < SCAN_PAGES;
  assign row_data = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    hit_any  = 1'b0;
    hit_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (row_data[l*CLASS_W +: CLASS_W] >= need_r) begin
        hit_any  = 1'b1;
        hit_lane = 4'(l);
      end
    end
  end

  always_comb begin
    wr_data = row_data;
    for (int l = 0; l < LANES; l++) begin
      if (upd_lane_r == 4'(l)) begin
        wr_data[l*CLASS_W +: CLASS_W] = cls_r;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_vld_nxt   = row_vld_r;
    scan_row_nxt  = scan_row_r;
    cmp_row_nxt   = cmp_row_r;
    cmp_vld_nxt   = cmp_vld_r;
    need_nxt      = need_r;
    cls_nxt       = cls_r;
    upd_row_nxt   = upd_row_r;
    upd_lane_nxt  = upd_lane_r;
    res_found_nxt = res_found_r;
    res_page_nxt  = res_page_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_found_nxt = out_found_r;
    out_page_nxt  = out_page_r;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = scan_row_r;
    wr_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = in_page_index[ROW_W+3:4];
        if (in_xfer) begin
          if (in_command == CMD_UPDATE) begin
            cls_nxt      = (|free_sh[BYTES_W-1:CLASS_W]) ? MAX_CLASS
                                                         : free_sh[CLASS_W-1:0];
            upd_row_nxt  = in_page_index[ROW_W+3:4];
            upd_lane_nxt = in_page_index[3:0];
            if (page_ok) begin
              rd_en     = 1'b1;
              state_nxt = ST_UPDATE;
            end
          end else begin
            need_nxt      = req_sh[CLASS_W-1:0] + CLASS_W'(1);
            scan_row_nxt  = '0;
            cmp_vld_nxt   = 1'b0;
            res_found_nxt = 1'b0;
            res_page_nxt  = '0;
            state_nxt     = need_big ? ST_RESP : ST_FIND;
          end
        end
      end
      ST_UPDATE: begin
        wr_en                  = 1'b1;
        row_vld_nxt[upd_row_r] = 1'b1;
        state_nxt              = ST_IDLE;
      end
      ST_FIND: begin
        // One row is read while the previously read row is compared.
        rd_en        = (scan_row_r <= LAST_ROW);
        scan_row_nxt = scan_row_r + ROW_W'(1);
        cmp_row_nxt  = scan_row_r;
        cmp_vld_nxt  = 1'b1;
        if (cmp_vld_r && (hit_any || cmp_row_r == LAST_ROW)) begin
          res_found_nxt = hit_any;
          res_page_nxt  = hit_any ? PAGE_W'({cmp_row_r, hit_lane}) : '0;
          state_nxt     = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_page_nxt  = res_page_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_vld_r   <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_row_r  <= scan_row_nxt;
    cmp_row_r   <= cmp_row_nxt;
    need_r      <= need_nxt;
    cls_r       <= cls_nxt;
    upd_row_r   <= upd_row_nxt;
    upd_lane_r  <= upd_lane_nxt;
    res_found_r <= res_found_nxt;
    res_page_r  <= res_page_nxt;
    out_found_r <= out_found_nxt;
    out_page_r  <= out_page_nxt;
  end

  // Map memory: one row of sixteen classes per entry, with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[upd_row_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= map_mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_page_found = out_page_r;

endmodule

/* sv/fsmff_checker.sv */
`timescale 1ns / 1ps

module fsmff_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_command,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_found,
  input logic [fsmff_pkg::PAGE_W-1:0]  out_page_found
);
  import fsmff_pkg::*;

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_page_found))
    else $error("result changed or dropped while stalled");

  // A miss always reports page zero.
  a_miss_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_page_found == '0)
    else $error("miss with nonzero page");

  // An update never produces a result.
  a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_UPDATE && !out_valid |=> !out_valid)
    else $error("result after an update");

  // A find keeps the input side closed for at least the next cycle.
  a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_FIND |=> !in_ready)
    else $error("input taken right after a find");

endmodule

bind free_space_map_first_fit fsmff_checker u_fsmff_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_command     (in_command),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_found      (out_found),
  .out_page_found (out_page_found)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Keeps its own copy of the class map and the shift, and queues one expected
// answer for every find transfer.
class first_fit_scoreboard;
  typedef struct {
    logic                         found;
    logic [fsmff_pkg::PAGE_W-1:0] page;
  } fit_t;

  logic [fsmff_pkg::CLASS_W-1:0] class_map [fsmff_pkg::MAX_PAGES];
  logic [fsmff_pkg::SHIFT_W-1:0] block_shift;
  fit_t                          expected_fits [$];
  int                            mismatches;

  function new();
    foreach (class_map[i]) class_map[i] = '0;
    block_shift = fsmff_pkg::SHIFT_RESET;
    mismatches  = 0;
  endfunction

  function int pending();
    return expected_fits.size();
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  function void note_transfer(logic                          cmd,
                              logic [fsmff_pkg::PAGE_W-1:0]  page,
                              logic [fsmff_pkg::BYTES_W-1:0] free_b,
                              logic [fsmff_pkg::BYTES_W-1:0] req);
    int unsigned cls;
    int unsigned need;
    fit_t        fit;
    if (cmd == fsmff_pkg::CMD_UPDATE) begin
      cls = 32'(free_b) >> block_shift;
      if (cls > fsmff_pkg::MAX_CLASS) cls = fsmff_pkg::MAX_CLASS;
      if (page < fsmff_pkg::MAX_PAGES) class_map[page] = cls[fsmff_pkg::CLASS_W-1:0];
    end else begin
      // A zero-byte request still needs one class.
      need      = (req == '0) ? 1 : ((32'(req) - 1) >> block_shift) + 1;
      fit.found = 1'b0;
      fit.page  = '0;
      if (need <= fsmff_pkg::MAX_CLASS) begin
        for (int i = 0; i < fsmff_pkg::MAX_PAGES; i++) begin
          if (class_map[i] >= need) begin
            fit.found = 1'b1;
            fit.page  = fsmff_pkg::PAGE_W'(i);
            break;
          end
        end
      end
      expected_fits = {expected_fits, fit};
    end
  endfunction

  task check_result(logic found, logic [fsmff_pkg::PAGE_W-1:0] page);
    fit_t fit;
    if (expected_fits.size() == 0) begin
      report_mismatch($sformatf("result found=%0d page=%0d with no find pending",
                                found, page));
      return;
    end
    fit = expected_fits.pop_front();
    if (found !== fit.found)
      report_mismatch($sformatf("found %0d, expected %0d", found, fit.found));
    if (page !== fit.page)
      report_mismatch($sformatf("page_found %0d, expected %0d", page, fit.page));
  endtask
endclass

module tb_top;
  import fsmff_pkg::*;

  localparam int PAGE_COUNT      = 1024;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int SETTLE_CYCLES   = 10;
  localparam int DRAIN_CYCLES    = 80;

  bit                  clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_command;
  logic [PAGE_W-1:0]   in_page_index;
  logic [BYTES_W-1:0]  in_free_bytes;
  logic [BYTES_W-1:0]  in_required_bytes;
  logic                out_valid;
  logic                out_ready;
  logic                out_found;
  logic [PAGE_W-1:0]   out_page_found;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [PADDR_W-1:0]  cfg_paddr;
  logic [PDATA_W-1:0]  cfg_pwdata;
  logic [PDATA_W-1:0]  cfg_prdata;
  logic                cfg_pready;

  first_fit_scoreboard fit_board = new();
  bit                  tx_gaps   = 1'b1;
  bit                  rx_stalls = 1'b1;
  int                  cycle_count = 0;

  free_space_map_first_fit #(
    .PAGE_COUNT(PAGE_COUNT)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_page_index    (in_page_index),
    .in_free_bytes    (in_free_bytes),
    .in_required_bytes(in_required_bytes),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_page_found   (out_page_found),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) fit_board.check_result(out_found, out_page_found);
      if (in_valid && in_ready)
        fit_board.note_transfer(in_command, in_page_index, in_free_bytes, in_required_bytes);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stalls while stalls are enabled.
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!rx_stalls || $urandom_range(0, 7) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 8);
      end
    end
  end

  task automatic send_item(logic cmd, logic [PAGE_W-1:0] page,
                           logic [BYTES_W-1:0] free_b, logic [BYTES_W-1:0] req);
    @(negedge clk);
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_page_index     <= page;
    in_free_bytes     <= free_b;
    in_required_bytes <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results(int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (fit_board.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Writes the shift and reads it back in the following transfer.
  task automatic write_block_shift(logic [SHIFT_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_BLOCK_SHIFT;
    cfg_pwdata  <= PDATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    fit_board.block_shift = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[SHIFT_W-1:0] !== value)
      fit_board.report_mismatch($sformatf("block_shift reads %0d, expected %0d",
                                          cfg_prdata[SHIFT_W-1:0], value));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Sizes are mostly drawn around class boundaries of the current shift so
  // that finds both hit and miss; pages favor the low end to keep scans short.
  task automatic send_random_item();
    int unsigned        mask;
    int unsigned        level;
    int unsigned        pick;
    logic               cmd;
    logic [PAGE_W-1:0]  page;
    logic [BYTES_W-1:0] free_b;
    logic [BYTES_W-1:0] req;
    mask  = (32'd1 << fit_board.block_shift) - 1;
    cmd   = ($urandom_range(0, 99) < 45) ? CMD_FIND : CMD_UPDATE;
    pick  = $urandom_range(0, 99);
    if (pick < 60)      page = PAGE_W'($urandom_range(0, 31));
    else if (pick < 85) page = PAGE_W'($urandom_range(0, 255));
    else                page = PAGE_W'($urandom);
    level = $urandom_range(0, 15);
    if ($urandom_range(0, 9) < 7)
      free_b = BYTES_W'((level << fit_board.block_shift) | ($urandom & mask));
    else
      free_b = BYTES_W'($urandom);
    pick  = $urandom_range(0, 9);
    level = $urandom_range(0, 15);
    if (pick == 0)     req = '0;
    else if (pick < 8) req = BYTES_W'((level << fit_board.block_shift) + 1 + ($urandom & mask));
    else               req = BYTES_W'($urandom);
    send_item(cmd, page, free_b, req);
  endtask

  initial begin
    int shift_plan [8];
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_command        = CMD_UPDATE;
    in_page_index     = '0;
    in_free_bytes     = '0;
    in_required_bytes = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset shift of 8, 256 bytes per class.
    send_item(CMD_FIND,   10'd0,    16'h0000, 16'h0000);  // empty map
    send_item(CMD_FIND,   10'd0,    16'h0000, 16'hFFFF);  // far more than 15 classes
    send_item(CMD_UPDATE, 10'd1023, 16'hFFFF, 16'h0000);  // saturates at 15
    send_item(CMD_UPDATE, 10'd0,    16'h0000, 16'h0000);
    send_item(CMD_FIND,   10'd0,    16'h0000, 16'h0000);  // zero request
    send_item(CMD_FIND,   10'd0,    16'h0000, 16'h0F00);  // exactly 15 classes
    send_item(CMD_FIND,   10'd0,    16'h0000, 16'h0F01);  // 16 classes
    send_item(CMD_UPDATE, 10'd512,  16'h01FF, 16'h0000);
    send_item(CMD_FIND,   10'd0,    16'h0000, 16'h0001);
    send_item(CMD_FIND,   10'd0,    16'h0000, 16'h0101);
    send_item(CMD_UPDATE, 10'd0,    16'h0F00, 16'h0000);
    send_item(CMD_FIND,   10'd0,    16'h0000, 16'h0100);
    send_item(CMD_UPDATE, 10'd0,    16'h00FF, 16'h0000);
    send_item(CMD_FIND,   10'd1023, 16'hFFFF, 16'h0001);
    send_item(CMD_UPDATE, 10'd341,  16'hAAAA, 16'h5555);
    send_item(CMD_UPDATE, 10'd682,  16'h5555, 16'hAAAA);
    send_item(CMD_FIND,   10'd0,    16'h0000, 16'hAAAA);
    send_item(CMD_FIND,   10'd0,    16'h0000, 16'h0555);
    send_item(CMD_UPDATE, 10'd341,  16'h0000, 16'h0000);
    send_item(CMD_FIND,   10'd341,  16'hAAAA, 16'h0555);

    shift_plan    = '{0, 12, 15, 4, 13, 14, 8, 0};
    shift_plan[7] = $urandom_range(0, 15);
    for (int p = 0; p < 8; p++) begin
      drain_results(SETTLE_CYCLES);
      write_block_shift(SHIFT_W'(shift_plan[p]));
      tx_gaps   = (p != 7) && ($urandom_range(0, 3) != 0);
      rx_stalls = (p != 7) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == ITEMS_PER_PHASE / 2) drain_results(0);
        if (tx_gaps && $urandom_range(0, 5) == 0) pause_input($urandom_range(1, 9));
        send_random_item();
      end
    end

    drain_results(DRAIN_CYCLES);
    if (fit_board.mismatches == 0 && fit_board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
